>>> rtl/worq_pkg.sv
// Shared types, codes and constants for the weight-ordered run queue.
`default_nettype none

package worq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int KIND_W    = 3;
    localparam int ID_W      = 8;
    localparam int IN_W_W    = 16;
    localparam int QCOUNT_W  = 5;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    localparam logic [IN_W_W-1:0] MAX_WEIGHT_RESET = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQUEUE = 3'd0,
        KIND_DEQUEUE = 3'd1,
        KIND_PICK    = 3'd2,
        KIND_TICK    = 3'd3,
        KIND_YIELD   = 3'd4,
        KIND_PREEMPT = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NOTFOUND = 2'd2,
        STATUS_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   task_id;
        logic [IN_W_W-1:0] task_weight;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]     picked_id;
        logic                picked_valid;
        logic                resched;
        status_t             status;
        logic [QCOUNT_W-1:0] queued_count;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/worq_slot_ram.sv
// Slot memory holding task id and weight pairs, one write and one registered read port.
`default_nettype none

module worq_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 24
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/worq_engine.sv
// Sequencer that scans and shifts the slot memory one entry per cycle for each item.
`default_nettype none

module worq_engine #(
    parameter int QUEUE_DEPTH = worq_pkg::QUEUE_DEPTH_DEF,
    parameter int WEIGHT_BITS = worq_pkg::WEIGHT_BITS_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_ready,
    input  wire worq_pkg::cmd_t                      cmd,
    input  wire logic [worq_pkg::IN_W_W-1:0]         max_weight,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output worq_pkg::result_t                        res,
    output logic [CNT_W-1:0]                         count_o
);

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ID_W   = worq_pkg::ID_W;
    localparam int DATA_W = WEIGHT_BITS + ID_W;
    localparam int QC_W   = worq_pkg::QCOUNT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_ADDR,
        ST_SCAN_CHK,
        ST_PICK_ADDR,
        ST_PICK_CHK,
        ST_SHUP_ADDR,
        ST_SHUP_WR,
        ST_WRITE_NEW,
        ST_SHDN_ADDR,
        ST_SHDN_WR,
        ST_FINISH_REMOVE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_ROT
    } op_t;

    state_t                state_reg;
    op_t                   op_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic [ID_W-1:0]       id_reg;
    logic [ID_W-1:0]       key_id_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [DATA_W-1:0]     hold_reg;
    logic [ID_W-1:0]       cur_task_reg;
    logic [WEIGHT_BITS-1:0] cur_weight_reg;
    logic                  cur_valid_reg;
    logic [ID_W-1:0]       picked_id_reg;
    logic                  picked_valid_reg;
    logic                  resched_reg;
    worq_pkg::status_t     status_reg;

    logic [WEIGHT_BITS-1:0] w_in;
    logic [WEIGHT_BITS-1:0] max_w;
    logic [CNT_W-1:0]      idx_p1;
    logic [CNT_W-1:0]      idx_p2;
    logic [CNT_W-1:0]      idx_m1;
    logic [CNT_W-1:0]      count_m1;
    logic [DATA_W-1:0]     rd_data;
    logic [ID_W-1:0]       rd_id;
    logic [WEIGHT_BITS-1:0] rd_w;
    logic                  hit;
    logic                  rot_ok;
    logic                  start;
    logic [CNT_W-1:0]      rd_idx;
    logic                  wr_en;
    logic [CNT_W-1:0]      wr_idx;
    logic [DATA_W-1:0]     wr_data;

    assign w_in     = WEIGHT_BITS'(cmd.task_weight);
    assign max_w    = WEIGHT_BITS'(max_weight);
    assign idx_p1   = idx_reg + CNT_W'(1);
    assign idx_p2   = idx_reg + CNT_W'(2);
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign count_m1 = count_reg - CNT_W'(1);
    assign rd_id    = rd_data[ID_W-1:0];
    assign rd_w     = rd_data[DATA_W-1:ID_W];
    assign hit      = (op_reg == OP_ENQ) ? (w_reg <= rd_w) : (rd_id == key_id_reg);
    assign rot_ok   = cur_valid_reg && (cur_weight_reg == max_w) && (count_reg != '0);
    assign start    = cmd_valid && cmd_ready;

    always_comb begin
        rd_idx  = idx_reg;
        wr_en   = 1'b0;
        wr_idx  = idx_reg;
        wr_data = rd_data;
        case (state_reg)
            ST_SCAN_CHK:  rd_idx = idx_p1;
            ST_PICK_ADDR: rd_idx = '0;
            ST_SHUP_WR: begin
                rd_idx = idx_m1;
                wr_en  = 1'b1;
                wr_idx = idx_p1;
            end
            ST_SHDN_ADDR: rd_idx = idx_p1;
            ST_SHDN_WR: begin
                rd_idx = idx_p2;
                wr_en  = 1'b1;
            end
            ST_WRITE_NEW: begin
                wr_en   = 1'b1;
                wr_idx  = pos_reg;
                wr_data = {w_reg, id_reg};
            end
            ST_FINISH_REMOVE: begin
                wr_en   = (op_reg == OP_ROT);
                wr_idx  = count_m1;
                wr_data = hold_reg;
            end
            default: rd_idx = idx_reg;
        endcase
    end

    worq_slot_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_idx[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            cur_task_reg   <= '0;
            cur_weight_reg <= '0;
            cur_valid_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        status_reg       <= worq_pkg::STATUS_OK;
                        resched_reg      <= 1'b0;
                        picked_id_reg    <= '0;
                        picked_valid_reg <= 1'b0;
                        idx_reg          <= '0;
                        id_reg           <= cmd.task_id;
                        w_reg            <= w_in;
                        key_id_reg       <= cur_task_reg;
                        op_reg           <= OP_ROT;
                        state_reg        <= ST_DONE;
                        case (cmd.kind)
                            worq_pkg::KIND_ENQUEUE: begin
                                op_reg <= OP_ENQ;
                                if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                                    status_reg <= worq_pkg::STATUS_FULL;
                                end else if (count_reg == '0) begin
                                    pos_reg   <= '0;
                                    state_reg <= ST_WRITE_NEW;
                                end else begin
                                    state_reg <= ST_SCAN_ADDR;
                                end
                            end
                            worq_pkg::KIND_DEQUEUE: begin
                                op_reg     <= OP_DEQ;
                                key_id_reg <= cmd.task_id;
                                if (count_reg == '0) begin
                                    status_reg <= worq_pkg::STATUS_EMPTY;
                                end else begin
                                    state_reg <= ST_SCAN_ADDR;
                                end
                            end
                            worq_pkg::KIND_PICK: begin
                                if (count_reg == '0) begin
                                    status_reg    <= worq_pkg::STATUS_EMPTY;
                                    cur_valid_reg <= 1'b0;
                                end else begin
                                    state_reg <= ST_PICK_ADDR;
                                end
                            end
                            worq_pkg::KIND_TICK: begin
                                if (cur_valid_reg && (cur_weight_reg == max_w) &&
                                    (count_reg > CNT_W'(1))) begin
                                    resched_reg <= 1'b1;
                                    state_reg   <= ST_SCAN_ADDR;
                                end
                            end
                            worq_pkg::KIND_YIELD: begin
                                if (rot_ok) begin
                                    state_reg <= ST_SCAN_ADDR;
                                end
                            end
                            worq_pkg::KIND_PREEMPT: begin
                                if (cur_valid_reg && (w_in < cur_weight_reg)) begin
                                    resched_reg <= 1'b1;
                                    if (rot_ok) begin
                                        state_reg <= ST_SCAN_ADDR;
                                    end
                                end
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_SCAN_ADDR: state_reg <= ST_SCAN_CHK;
                ST_SCAN_CHK: begin
                    if (hit) begin
                        pos_reg  <= idx_reg;
                        hold_reg <= rd_data;
                        if (op_reg == OP_ENQ) begin
                            idx_reg   <= count_m1;
                            state_reg <= ST_SHUP_ADDR;
                        end else if (idx_p1 == count_reg) begin
                            state_reg <= ST_FINISH_REMOVE;
                        end else begin
                            state_reg <= ST_SHDN_ADDR;
                        end
                    end else if (idx_p1 == count_reg) begin
                        if (op_reg == OP_ENQ) begin
                            pos_reg   <= count_reg;
                            state_reg <= ST_WRITE_NEW;
                        end else begin
                            if (op_reg == OP_DEQ) begin
                                status_reg <= worq_pkg::STATUS_NOTFOUND;
                            end
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        idx_reg <= idx_p1;
                    end
                end
                ST_PICK_ADDR: state_reg <= ST_PICK_CHK;
                ST_PICK_CHK: begin
                    picked_id_reg    <= rd_id;
                    picked_valid_reg <= 1'b1;
                    cur_task_reg     <= rd_id;
                    cur_weight_reg   <= rd_w;
                    cur_valid_reg    <= 1'b1;
                    state_reg        <= ST_DONE;
                end
                ST_SHUP_ADDR: state_reg <= ST_SHUP_WR;
                ST_SHUP_WR: begin
                    if (idx_reg == pos_reg) begin
                        state_reg <= ST_WRITE_NEW;
                    end else begin
                        idx_reg <= idx_m1;
                    end
                end
                ST_WRITE_NEW: begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ST_DONE;
                end
                ST_SHDN_ADDR: state_reg <= ST_SHDN_WR;
                ST_SHDN_WR: begin
                    if (idx_p2 == count_reg) begin
                        state_reg <= ST_FINISH_REMOVE;
                    end else begin
                        idx_reg <= idx_p1;
                    end
                end
                ST_FINISH_REMOVE: begin
                    if (op_reg == OP_DEQ) begin
                        count_reg <= count_m1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign count_o   = count_reg;

    always_comb begin
        res.picked_id    = picked_id_reg;
        res.picked_valid = picked_valid_reg;
        res.resched      = resched_reg;
        res.status       = status_reg;
        res.queued_count = QC_W'(count_reg);
    end

endmodule

`default_nettype wire

>>> rtl/weight_ordered_run_queue_top.sv
// Top level of the weight-ordered run queue with stream ports and the max weight register.
`default_nettype none

// A run queue of up to QUEUE_DEPTH task ids kept in ascending weight order in a slot memory
// with one write port and one registered read port. Each input item is one scheduler event
// (enqueue, dequeue, pick, tick, yield, check preempt) and produces exactly one result item.
// The block takes one item at a time: s_tready is high only while the sequencer is idle.
// The sequencer walks the slot memory one entry per cycle, first to search for the insertion
// point or the task id, then to shift the entries behind it. A finished result sits in the
// output register, so the next item is accepted while the result waits for m_tready.
// max_weight is written through cfg_wr_en and cfg_wr_data; the user must write it only while
// the block is idle, and the block itself does not enforce this.
module weight_ordered_run_queue_top #(
    parameter int QUEUE_DEPTH = worq_pkg::QUEUE_DEPTH_DEF,
    parameter int WEIGHT_BITS = worq_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // task_id [7:0], task_weight [23:8]
    input  wire logic [worq_pkg::S_DATA_W-1:0]     s_tdata,
    // kind [2:0]
    input  wire logic [worq_pkg::KIND_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // picked_id [7:0], picked_valid [8], resched [9], status [11:10],
    // queued_count [16:12], zero [23:17]
    output logic [worq_pkg::M_DATA_W-1:0]          m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [worq_pkg::IN_W_W-1:0]       cfg_wr_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W  = worq_pkg::ID_W;
    localparam int PAD_W = worq_pkg::M_DATA_W - ID_W - 4 - worq_pkg::QCOUNT_W;

    logic [worq_pkg::IN_W_W-1:0]   max_weight_reg;
    logic                          m_tvalid_reg;
    logic [worq_pkg::M_DATA_W-1:0] m_tdata_reg;

    worq_pkg::cmd_t    cmd;
    worq_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;
    logic [CNT_W-1:0]  eng_count;

    always_comb begin
        cmd.kind        = worq_pkg::kind_t'(s_tuser);
        cmd.task_id     = s_tdata[ID_W-1:0];
        cmd.task_weight = s_tdata[ID_W +: worq_pkg::IN_W_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_weight_reg <= worq_pkg::MAX_WEIGHT_RESET;
        end else if (cfg_wr_en) begin
            max_weight_reg <= cfg_wr_data;
        end
    end

    worq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS),
        .CNT_W       (CNT_W)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (s_tvalid),
        .cmd_ready  (s_tready),
        .cmd        (cmd),
        .max_weight (max_weight_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .count_o    (eng_count)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, res.queued_count, res.status, res.resched,
                            res.picked_valid, res.picked_id};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer ready right after taking an item");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.status == worq_pkg::STATUS_FULL)) |->
        (eng_count == CNT_W'(QUEUE_DEPTH)))
        else $error("full status with free slots");

    a_pick_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.picked_valid) |->
        ((res.status == worq_pkg::STATUS_OK) && !res.resched && (eng_count != '0)))
        else $error("pick result inconsistent");

endmodule

`default_nettype wire

>>> dv/tb_weight_ordered_run_queue_top.sv
// Self-checking testbench for the weight-ordered run queue: directed and random scheduler events.
`timescale 1ns / 1ps

module tb_weight_ordered_run_queue_top;
    import worq_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int SETTLE_TICKS = 2 * DEPTH + 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 125;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata     = '0;
    logic [KIND_W-1:0]   s_tuser     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wr_en   = 1'b0;
    logic [IN_W_W-1:0]   cfg_wr_data = '0;

    logic [ID_W-1:0]   rq_id [DEPTH];
    logic [IN_W_W-1:0] rq_wt [DEPTH];
    int                rq_len = 0;
    logic [ID_W-1:0]   cur_id = '0;
    logic [IN_W_W-1:0] cur_wt = '0;
    logic              cur_ok = 1'b0;
    logic [IN_W_W-1:0] max_wt = MAX_WEIGHT_RESET;

    result_t pending_results[$];
    bit      idling_on    = 1'b1;
    int      stall_left   = 0;
    int      err_count    = 0;
    int      items_sent   = 0;
    int      results_seen = 0;
    int      cfg_writes   = 0;
    int      full_hits    = 0;

    weight_ordered_run_queue_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int find_task(logic [ID_W-1:0] id);
        for (int i = 0; i < rq_len; i++) begin
            if (rq_id[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic void remove_slot(int pos);
        for (int i = pos; i + 1 < rq_len; i++) begin
            rq_id[i] = rq_id[i + 1];
            rq_wt[i] = rq_wt[i + 1];
        end
        rq_len--;
    endfunction

    // A current task at max weight that is still queued goes to the tail.
    function automatic void rotate_current();
        int                pos;
        logic [ID_W-1:0]   id;
        logic [IN_W_W-1:0] w;
        if (!cur_ok || cur_wt != max_wt) return;
        pos = find_task(cur_id);
        if (pos < 0) return;
        id = rq_id[pos];
        w  = rq_wt[pos];
        remove_slot(pos);
        rq_id[rq_len] = id;
        rq_wt[rq_len] = w;
        rq_len++;
    endfunction

    function automatic result_t apply_event(kind_t kind, logic [ID_W-1:0] id,
                                            logic [IN_W_W-1:0] w);
        result_t r;
        int      pos;
        r = '0;
        r.status = STATUS_OK;
        case (kind)
            KIND_ENQUEUE: begin
                if (rq_len >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    pos = rq_len;
                    for (int i = rq_len - 1; i >= 0; i--) begin
                        if (w <= rq_wt[i]) pos = i;
                    end
                    for (int i = rq_len; i > pos; i--) begin
                        rq_id[i] = rq_id[i - 1];
                        rq_wt[i] = rq_wt[i - 1];
                    end
                    rq_id[pos] = id;
                    rq_wt[pos] = w;
                    rq_len++;
                end
            end
            KIND_DEQUEUE: begin
                if (rq_len == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    pos = find_task(id);
                    if (pos < 0) r.status = STATUS_NOTFOUND;
                    else remove_slot(pos);
                end
            end
            KIND_PICK: begin
                if (rq_len == 0) begin
                    r.status = STATUS_EMPTY;
                    cur_ok   = 1'b0;
                end else begin
                    r.picked_id    = rq_id[0];
                    r.picked_valid = 1'b1;
                    cur_id         = rq_id[0];
                    cur_wt         = rq_wt[0];
                    cur_ok         = 1'b1;
                end
            end
            KIND_TICK: begin
                if (cur_ok && cur_wt == max_wt && rq_len > 1) begin
                    rotate_current();
                    r.resched = 1'b1;
                end
            end
            KIND_YIELD: begin
                rotate_current();
            end
            KIND_PREEMPT: begin
                if (cur_ok && w < cur_wt) begin
                    rotate_current();
                    r.resched = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.queued_count = rq_len[QCOUNT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    task automatic send_item(kind_t kind, logic [ID_W-1:0] id, logic [IN_W_W-1:0] w);
        result_t r;
        if (idling_on && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            repeat (($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1))
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {w, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = apply_event(kind, id, w);
        if (r.status == STATUS_FULL) full_hits++;
        pending_results.push_back(r);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_max_weight(logic [IN_W_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        max_wt = v;
        cfg_writes++;
    endtask

    task automatic test_empty_queue();
        send_item(KIND_DEQUEUE, 8'h5A, 16'h0000);
        send_item(KIND_PICK, 8'h00, 16'h0000);
        send_item(KIND_TICK, 8'h00, 16'h0000);
        send_item(KIND_YIELD, 8'h00, 16'h0000);
        send_item(KIND_PREEMPT, 8'h00, 16'h0000);
    endtask

    task automatic test_round_robin();
        send_item(KIND_ENQUEUE, 8'hFF, 16'hFFFF);
        // An equal weight goes in front of the entry already queued.
        send_item(KIND_ENQUEUE, 8'h00, 16'hFFFF);
        send_item(KIND_PICK, 8'h00, 16'h0000);
        send_item(KIND_TICK, 8'h00, 16'h0000);
        send_item(KIND_PREEMPT, 8'h00, 16'hFFFF);
        send_item(KIND_PREEMPT, 8'h00, 16'h0000);
        send_item(KIND_YIELD, 8'h00, 16'h0000);
        send_item(KIND_PICK, 8'h00, 16'h0000);
        send_item(KIND_YIELD, 8'h00, 16'h0000);
    endtask

    task automatic test_dequeue_cases();
        send_item(KIND_DEQUEUE, 8'd77, 16'h0000);
        // The duplicate id lands at the head, so it is the one removed.
        send_item(KIND_ENQUEUE, 8'h00, 16'h8000);
        send_item(KIND_DEQUEUE, 8'h00, 16'h0000);
        // Removing the current task leaves it current but no longer queued.
        send_item(KIND_DEQUEUE, 8'hFF, 16'h0000);
        send_item(KIND_ENQUEUE, 8'h03, 16'hFFFF);
        send_item(KIND_TICK, 8'h00, 16'h0000);
    endtask

    task automatic test_full_queue();
        send_item(KIND_ENQUEUE, 8'hA5, 16'h0000);
        while (rq_len < DEPTH)
            send_item(KIND_ENQUEUE, 8'($urandom), 16'($urandom));
        send_item(KIND_ENQUEUE, 8'h42, 16'h1234);
    endtask

    task automatic random_event(int mode);
        int                roll;
        int                enq_share;
        int                deq_share;
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [IN_W_W-1:0] w;
        enq_share = (mode == 0) ? 50 : (mode == 1) ? 30 : 15;
        deq_share = (mode == 2) ? 40 : 20;
        roll = $urandom_range(99);
        if (roll < enq_share) begin
            kind = KIND_ENQUEUE;
        end else if (roll < enq_share + deq_share) begin
            kind = KIND_DEQUEUE;
        end else begin
            case ($urandom_range(4))
                0, 1:    kind = KIND_PICK;
                2:       kind = KIND_TICK;
                3:       kind = KIND_YIELD;
                default: kind = KIND_PREEMPT;
            endcase
        end
        if (rq_len > 0 && $urandom_range(9) < 7) id = rq_id[$urandom_range(rq_len - 1)];
        else if ($urandom_range(1) == 0) id = 8'($urandom_range(15));
        else id = 8'($urandom_range(255));
        case ($urandom_range(9))
            0, 1, 2: w = max_wt;
            3:       w = 16'h0000;
            4:       w = 16'hFFFF;
            5:       w = (rq_len > 0) ? rq_wt[$urandom_range(rq_len - 1)] : 16'($urandom);
            6:       w = cur_wt - 16'd1;
            7:       w = cur_wt;
            default: w = 16'($urandom_range(65535));
        endcase
        send_item(kind, id, w);
    endtask

    task automatic test_random_traffic();
        logic [IN_W_W-1:0] settings [PHASES];
        settings[0] = 16'h0000;
        settings[1] = 16'hFFFF;
        settings[2] = 16'($urandom);
        settings[3] = 16'h0001;
        settings[4] = 16'hFFFE;
        settings[5] = 16'($urandom);
        settings[6] = 16'h8000;
        settings[7] = 16'($urandom);
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_max_weight(settings[p]);
            // The second phase runs with both sides always ready.
            idling_on = (p != 1);
            for (int i = 0; i < PHASE_ITEMS; i++) random_event(p % 3);
        end
        idling_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idling_on && $urandom_range(99) < 15) begin
            stall_left <= ($urandom_range(19) == 0) ? $urandom_range(30, 5) : 0;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: m_tdata=%h", m_tdata);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                check_field("picked_id", want.picked_id, m_tdata[7:0]);
                check_field("picked_valid", want.picked_valid, m_tdata[8]);
                check_field("resched", want.resched, m_tdata[9]);
                check_field("status", want.status, m_tdata[11:10]);
                check_field("queued_count", want.queued_count, m_tdata[16:12]);
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_queue();
        test_round_robin();
        test_dequeue_cases();
        test_full_queue();
        test_random_traffic();
        wait_idle();
        repeat (SETTLE_TICKS) @(posedge aclk);
        $display("Ran %0d scheduler items under %0d max_weight settings, %0d results checked.",
                 items_sent, cfg_writes + 1, results_seen);
        $display("Enqueues rejected on a full queue: %0d.", full_hits);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
